FILE: rtl/ehb_pkg.sv
`timescale 1ns / 1ps
package ehb_pkg;
  localparam int unsigned GridSide = 64;
  localparam int unsigned IdxW = 6;
  localparam int unsigned AddrW = 12;
  localparam int unsigned Depth = 4096;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [7:0] PixMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH = 2'd0,
    CFG_STEP       = 2'd1,
    CFG_GRID_COUNT = 2'd2,
    CFG_LOG_MODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [31:0]      source_vertex;
    logic [31:0]      dest_vertex;
    logic [IdxW-1:0]  read_row;
    logic [IdxW-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       edge_dropped;
  } out_item_t;

  // classified operation passed from front to back
  typedef struct packed {
    logic             is_read;
    logic             dropped;
    logic [AddrW-1:0] addr;
  } op_t;

  typedef struct packed {
    logic [31:0] grid_width;
    logic [7:0]  step;
    logic [6:0]  grid_count;
    logic        log_mode;
  } cfg_t;
endpackage

FILE: rtl/ehb_if.sv
`timescale 1ns / 1ps
interface ehb_in_if;
  logic              valid;
  logic              ready;
  ehb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ehb_out_if;
  logic               valid;
  logic               ready;
  ehb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/edge_heatmap_binning.sv
`timescale 1ns / 1ps
// Edge heatmap binning: a 64x64 saturating 2-D histogram of graph edges.
// in_if carries one transaction per item: action 0 adds the edge
// (source_vertex, dest_vertex) to bin (src/grid_width, dst/grid_width);
// action 1 reads bin (read_row, read_col). out_if returns one transaction
// per item: pixel_value (0 for adds) and edge_dropped (out-of-grid adds).
// Configuration writes via cfg_we_i / cfg_idx_i / cfg_data_i, while idle.
// Adds pass a 32-step serial divider in the front and a read-modify-write
// in the back; log-mode reads also take 8 serial squarings for the log2
// fraction. The front takes no new item while an add is in its divider;
// reads pipeline behind adds through a two-entry queue.
// After reset the back clears the 4096-word store, one word per cycle;
// adds may enter the front meanwhile, config is taken.
// A stalled receiver holds the result; the queue then fills and the
// front stops accepting.
module edge_heatmap_binning (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ehb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ehb_pkg::CfgDataW-1:0] cfg_data_i,
  ehb_in_if.sink                       in_if,
  ehb_out_if.source                    out_if
);
  import ehb_pkg::*;
  cfg_t cfg_q;
  logic f_valid, f_ready, b_valid, b_ready;
  op_t  f_op, b_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{grid_width: 32'd2048, step: 8'd1, grid_count: 7'd64, log_mode: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_WIDTH: cfg_q.grid_width <= cfg_data_i;
        CFG_STEP:       cfg_q.step <= cfg_data_i[7:0];
        CFG_GRID_COUNT: cfg_q.grid_count <= cfg_data_i[6:0];
        CFG_LOG_MODE:   cfg_q.log_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ehb_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .op_valid_o(f_valid), .op_ready_i(f_ready), .op_o(f_op)
  );
  ehb_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_op),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_op)
  );
  ehb_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .op_valid_i(b_valid), .op_ready_o(b_ready), .op_i(b_op),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );

  a_read_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.pixel_value != 8'd0 |-> !out_if.data.edge_dropped)
    else $error("read flagged dropped");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result lost");
  a_q_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid && b_ready |=> !out_if.valid) else $error("back overlap");
endmodule

FILE: rtl/ehb_front.sv
`timescale 1ns / 1ps
// Bit-serial restoring division of both vertices by grid_width, then bin check.
module ehb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ehb_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ehb_pkg::in_item_t in_data_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output ehb_pkg::op_t      op_o
);
  import ehb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_e;
  state_e      state_q;
  logic [4:0]  cnt_q;
  logic [31:0] qs_q, qd_q;
  logic [32:0] rs_q, rd_q;
  logic [31:0] div_q;
  op_t         op_q;
  logic [32:0] rs_sh, rd_sh;
  logic        bs, bd;
  logic [31:0] qs_nx, qd_nx;
  logic        drop;

  assign rs_sh = {rs_q[31:0], qs_q[31]};
  assign rd_sh = {rd_q[31:0], qd_q[31]};
  assign bs = rs_sh >= {1'b0, div_q};
  assign bd = rd_sh >= {1'b0, div_q};
  assign qs_nx = {qs_q[30:0], bs};
  assign qd_nx = {qd_q[30:0], bd};
  // final quotient row/col valid only if upper bits zero and below grid_count
  assign drop = (qs_nx[31:IdxW] != '0) || (qd_nx[31:IdxW] != '0) ||
                ({26'd0, qs_nx[IdxW-1:0]} >= {25'd0, cfg_i.grid_count}) ||
                ({26'd0, qd_nx[IdxW-1:0]} >= {25'd0, cfg_i.grid_count});

  assign in_ready_o = (state_q == S_IDLE);
  assign op_valid_o = (state_q == S_OUT);
  assign op_o = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.action == ACT_READ) begin
              op_q    <= '{is_read: 1'b1, dropped: 1'b0,
                           addr: {in_data_i.read_row, in_data_i.read_col}};
              state_q <= S_OUT;
            end else begin
              qs_q    <= in_data_i.source_vertex;
              qd_q    <= in_data_i.dest_vertex;
              rs_q    <= '0;
              rd_q    <= '0;
              div_q   <= (cfg_i.grid_width == '0) ? 32'd1 : cfg_i.grid_width;
              cnt_q   <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rs_q  <= bs ? rs_sh - {1'b0, div_q} : rs_sh;
          rd_q  <= bd ? rd_sh - {1'b0, div_q} : rd_sh;
          qs_q  <= qs_nx;
          qd_q  <= qd_nx;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= S_OUT;
            op_q    <= '{is_read: 1'b0, dropped: drop,
                         addr: {qs_nx[IdxW-1:0], qd_nx[IdxW-1:0]}};
          end
        end
        S_OUT: begin
          if (op_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/ehb_queue.sv
`timescale 1ns / 1ps
// Two-entry op queue between front and back.
module ehb_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  ehb_pkg::op_t wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output ehb_pkg::op_t rd_data_o
);
  import ehb_pkg::*;
  op_t        mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue overflow");
endmodule

FILE: rtl/ehb_back.sv
`timescale 1ns / 1ps
// Store sequencer: clear sweep, read-modify-write, log2 brightness.
module ehb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ehb_pkg::cfg_t      cfg_i,
  input  logic               op_valid_i,
  output logic               op_ready_o,
  input  ehb_pkg::op_t       op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ehb_pkg::out_item_t out_data_o
);
  import ehb_pkg::*;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EXEC, S_LOG, S_MUL, S_OUT}
    state_e;
  state_e           state_q;
  logic [31:0]      mem [Depth];
  logic [31:0]      rdata_q;
  logic [AddrW:0]   clr_q;
  op_t              op_q;
  logic [3:0]       it_q;
  logic [4:0]       e_q;
  logic [32:0]      m_q;
  logic [7:0]       frac_q;
  logic [15:0]      prod;
  out_item_t        res_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      wdata;
  logic [4:0]       msb;
  logic [65:0]      sq;
  logic [32:0]      sqs;
  logic [8:0]       lin_sum;
  logic [12:0]      lval;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) if (rdata_q[i]) msb = 5'(i);
  end
  assign sq  = m_q * m_q;
  assign sqs = sq[63:31];
  assign lin_sum = {1'b0, rdata_q[7:0]} + {1'b0, cfg_i.step};
  assign lval = {e_q, frac_q};
  assign prod = 16'(({13'd0, cfg_i.step} * {8'd0, lval}) >> 8);

  assign op_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign out_data_o  = res_q;

  always_comb begin
    we = 1'b0; waddr = op_q.addr; wdata = rdata_q;
    if (state_q == S_CLR) begin
      we = 1'b1; waddr = clr_q[AddrW-1:0]; wdata = '0;
    end else if (state_q == S_EXEC && !op_q.is_read && !op_q.dropped) begin
      if (cfg_i.log_mode) begin
        we = rdata_q != 32'hFFFF_FFFF; wdata = rdata_q + 32'd1;
      end else begin
        we = (rdata_q[31:8] == '0) && (lin_sum <= 9'd255);
        wdata = {23'd0, lin_sum};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[op_q.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[AddrW-1:0] == '1) state_q <= S_IDLE;
        end
        S_IDLE: if (op_valid_i) begin
          op_q <= op_i; state_q <= S_RD;
        end
        S_RD: state_q <= S_EXEC;
        S_EXEC: begin
          res_q <= '{pixel_value: 8'd0, edge_dropped: op_q.dropped && !op_q.is_read};
          if (!op_q.is_read) state_q <= S_OUT;
          else if (!cfg_i.log_mode) begin
            res_q.pixel_value <= (rdata_q[31:8] != '0) ? PixMax : rdata_q[7:0];
            state_q <= S_OUT;
          end else if (rdata_q == '0) state_q <= S_OUT;
          else begin
            e_q <= msb; m_q <= {1'b0, rdata_q << (5'd31 - msb)};
            it_q <= '0; frac_q <= '0; state_q <= S_LOG;
          end
        end
        S_LOG: begin
          // one squaring per cycle, eight fraction bits
          frac_q <= {frac_q[6:0], sqs[32]};
          m_q    <= sqs[32] ? {1'b0, sqs[32:1]} : sqs;
          it_q   <= it_q + 4'd1;
          if (it_q == 4'd7) state_q <= S_MUL;
        end
        S_MUL: begin
          res_q.pixel_value <= (prod[15:8] != '0) ? PixMax : prod[7:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
